// File: src/vau_pkg.sv
`default_nettype none

package vau_pkg;

    localparam int COMPONENT_WIDTH_DEFAULT     = 16;
    localparam int ANGLE_FRACTION_BITS_DEFAULT = 7;

    localparam int CORDIC_STEPS  = 23;
    localparam int ACC_FRAC      = 16;
    localparam int PRESCALE_BITS = 22;
    localparam int XY_WIDTH      = 60;
    localparam int Z_WIDTH       = 26;

    localparam int PADDR_WIDTH = 1;
    localparam logic [PADDR_WIDTH-1:0] ADDR_SIGNED_MODE = '0;

    typedef struct packed {
        logic degenerate;
        logic cross_y_pos;
    } vau_side_t;

    // atan(2^-i) in degrees, scaled by 2^16
    function automatic logic signed [Z_WIDTH-1:0] atan_entry(input int i);
        logic signed [Z_WIDTH-1:0] v;
        case (i)
            0:  v = 26'sd2949120;
            1:  v = 26'sd1740967;
            2:  v = 26'sd919879;
            3:  v = 26'sd466945;
            4:  v = 26'sd234379;
            5:  v = 26'sd117304;
            6:  v = 26'sd58666;
            7:  v = 26'sd29335;
            8:  v = 26'sd14668;
            9:  v = 26'sd7334;
            10: v = 26'sd3667;
            11: v = 26'sd1833;
            12: v = 26'sd917;
            13: v = 26'sd458;
            14: v = 26'sd229;
            15: v = 26'sd115;
            16: v = 26'sd57;
            17: v = 26'sd29;
            18: v = 26'sd14;
            19: v = 26'sd7;
            20: v = 26'sd4;
            21: v = 26'sd2;
            22: v = 26'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// File: src/vau_cordic.sv
`default_nettype none

module vau_cordic (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    input  logic signed [vau_pkg::XY_WIDTH-1:0]     in_x,
    input  logic signed [vau_pkg::XY_WIDTH-1:0]     in_y,
    input  vau_pkg::vau_side_t                      in_side,
    output logic                                    out_valid,
    output logic signed [vau_pkg::Z_WIDTH-1:0]      out_z,
    output vau_pkg::vau_side_t                      out_side
);
    import vau_pkg::*;

    logic                       valid_reg [0:CORDIC_STEPS];
    logic signed [XY_WIDTH-1:0] x_reg     [0:CORDIC_STEPS];
    logic signed [XY_WIDTH-1:0] y_reg     [0:CORDIC_STEPS];
    logic signed [Z_WIDTH-1:0]  z_reg     [0:CORDIC_STEPS];
    vau_side_t                  side_reg  [0:CORDIC_STEPS];

    // quadrant fold: left half plane rotated by -90 degrees
    logic signed [XY_WIDTH-1:0] x0_next, y0_next;
    logic signed [Z_WIDTH-1:0]  z0_next;

    always_comb
    begin
        if (in_x < 0)
        begin
            x0_next = in_y;
            y0_next = -in_x;
            z0_next = Z_WIDTH'(90) <<< ACC_FRAC;
        end
        else
        begin
            x0_next = in_x;
            y0_next = in_y;
            z0_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg[0]    <= x0_next;
        y_reg[0]    <= y0_next;
        z_reg[0]    <= z0_next;
        side_reg[0] <= in_side;
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        logic signed [XY_WIDTH-1:0] x_next, y_next;
        logic signed [Z_WIDTH-1:0]  z_next;

        always_comb
        begin
            if (y_reg[i] >= 0)
            begin
                x_next = x_reg[i] + (y_reg[i] >>> i);
                y_next = y_reg[i] - (x_reg[i] >>> i);
                z_next = z_reg[i] + atan_entry(i);
            end
            else
            begin
                x_next = x_reg[i] - (y_reg[i] >>> i);
                y_next = y_reg[i] + (x_reg[i] >>> i);
                z_next = z_reg[i] - atan_entry(i);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i+1] <= 1'b0;
            end
            else
            begin
                valid_reg[i+1] <= valid_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            x_reg[i+1]    <= x_next;
            y_reg[i+1]    <= y_next;
            z_reg[i+1]    <= z_next;
            side_reg[i+1] <= side_reg[i];
        end
    end

    assign out_valid = valid_reg[CORDIC_STEPS];
    assign out_z     = z_reg[CORDIC_STEPS];
    assign out_side  = side_reg[CORDIC_STEPS];

endmodule

`default_nettype wire

// File: src/vector_angle_unit.sv
// Throughput: one transaction per cycle; busy is always low.
// Pipeline: 8 front stages, 32-stage square root, 24-stage CORDIC, output stage.
// The receiver cannot stall; done marks a result for one cycle.
// Reset clears all valid bits and sets signed_mode to 1.
`default_nettype none

module vector_angle_unit #(
    parameter int COMPONENT_WIDTH     = vau_pkg::COMPONENT_WIDTH_DEFAULT,
    parameter int ANGLE_FRACTION_BITS = vau_pkg::ANGLE_FRACTION_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [COMPONENT_WIDTH-1:0]   ax,
    input  logic signed [COMPONENT_WIDTH-1:0]   ay,
    input  logic signed [COMPONENT_WIDTH-1:0]   az,
    input  logic signed [COMPONENT_WIDTH-1:0]   bx,
    input  logic signed [COMPONENT_WIDTH-1:0]   by_comp,
    input  logic signed [COMPONENT_WIDTH-1:0]   bz,
    output logic                                done,
    output logic signed [15:0]                  angle_deg,
    output logic                                degenerate,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [vau_pkg::PADDR_WIDTH-1:0]     paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import vau_pkg::*;

    localparam int FIT_SPAN = (COMPONENT_WIDTH > 16) ? COMPONENT_WIDTH - 16 : 0;
    localparam int SQRT_STEPS = 32;
    localparam int LATENCY = 8 + SQRT_STEPS + 1 + CORDIC_STEPS + 1;

    // config
    logic signed_mode_reg;
    logic cfg_write;

    assign pready    = 1'b1;
    assign busy      = 1'b0;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr == ADDR_SIGNED_MODE) ? {31'b0, signed_mode_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            signed_mode_reg <= 1'b1;
        end
        else if (cfg_write && paddr == ADDR_SIGNED_MODE)
        begin
            signed_mode_reg <= pwdata[0];
        end
    end

    // stage 1: capture
    logic                              s1_valid_reg;
    logic                              s1_deg_reg;
    logic signed [COMPONENT_WIDTH-1:0] s1_a_reg [0:2];
    logic signed [COMPONENT_WIDTH-1:0] s1_b_reg [0:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_a_reg[0] <= ax;
        s1_a_reg[1] <= ay;
        s1_a_reg[2] <= az;
        s1_b_reg[0] <= bx;
        s1_b_reg[1] <= by_comp;
        s1_b_reg[2] <= bz;
        s1_deg_reg  <= (ax == '0 && ay == '0 && az == '0) ||
                       (bx == '0 && by_comp == '0 && bz == '0);
    end

    // stage 2: common right shift into 16 bits
    function automatic logic [47:0] fit16(input logic signed [COMPONENT_WIDTH-1:0] v0,
                                          input logic signed [COMPONENT_WIDTH-1:0] v1,
                                          input logic signed [COMPONENT_WIDTH-1:0] v2);
        logic signed [63:0] e0, e1, e2;
        logic signed [63:0] t0, t1, t2;
        int sel;
        e0  = 64'(v0);
        e1  = 64'(v1);
        e2  = 64'(v2);
        sel = FIT_SPAN;
        for (int k = FIT_SPAN; k >= 0; k--)
        begin
            t0 = e0 >>> (15 + k);
            t1 = e1 >>> (15 + k);
            t2 = e2 >>> (15 + k);
            if ((t0 == 0 || t0 == -1) && (t1 == 0 || t1 == -1) && (t2 == 0 || t2 == -1))
            begin
                sel = k;
            end
        end
        t0 = e0 >>> sel;
        t1 = e1 >>> sel;
        t2 = e2 >>> sel;
        return {t2[15:0], t1[15:0], t0[15:0]};
    endfunction

    logic               s2_valid_reg;
    logic               s2_deg_reg;
    logic signed [15:0] s2_a_reg [0:2];
    logic signed [15:0] s2_b_reg [0:2];
    logic [47:0]        fa_next, fb_next;

    assign fa_next = fit16(s1_a_reg[0], s1_a_reg[1], s1_a_reg[2]);
    assign fb_next = fit16(s1_b_reg[0], s1_b_reg[1], s1_b_reg[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_a_reg[0] <= fa_next[15:0];
        s2_a_reg[1] <= fa_next[31:16];
        s2_a_reg[2] <= fa_next[47:32];
        s2_b_reg[0] <= fb_next[15:0];
        s2_b_reg[1] <= fb_next[31:16];
        s2_b_reg[2] <= fb_next[47:32];
        s2_deg_reg  <= s1_deg_reg;
    end

    // stage 3: partial products
    logic               s3_valid_reg;
    logic               s3_deg_reg;
    logic signed [31:0] p_xx_reg, p_yy_reg, p_zz_reg;
    logic signed [31:0] p_yz_reg, p_zy_reg, p_zx_reg, p_xz_reg, p_xy_reg, p_yx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p_xx_reg   <= s2_a_reg[0] * s2_b_reg[0];
        p_yy_reg   <= s2_a_reg[1] * s2_b_reg[1];
        p_zz_reg   <= s2_a_reg[2] * s2_b_reg[2];
        p_yz_reg   <= s2_a_reg[1] * s2_b_reg[2];
        p_zy_reg   <= s2_a_reg[2] * s2_b_reg[1];
        p_zx_reg   <= s2_a_reg[2] * s2_b_reg[0];
        p_xz_reg   <= s2_a_reg[0] * s2_b_reg[2];
        p_xy_reg   <= s2_a_reg[0] * s2_b_reg[1];
        p_yx_reg   <= s2_a_reg[1] * s2_b_reg[0];
        s3_deg_reg <= s2_deg_reg;
    end

    // stage 4: dot and cross
    logic               s4_valid_reg;
    logic               s4_deg_reg;
    logic signed [32:0] s4_d_reg, s4_c0_reg, s4_c1_reg, s4_c2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s4_d_reg   <= 33'(p_xx_reg) + 33'(p_yy_reg) + 33'(p_zz_reg);
        s4_c0_reg  <= 33'(p_yz_reg) - 33'(p_zy_reg);
        s4_c1_reg  <= 33'(p_zx_reg) - 33'(p_xz_reg);
        s4_c2_reg  <= 33'(p_xy_reg) - 33'(p_yx_reg);
        s4_deg_reg <= s3_deg_reg;
    end

    // stage 5: squares of cross magnitudes
    logic               s5_valid_reg;
    vau_side_t          s5_side_reg;
    logic signed [32:0] s5_d_reg;
    logic [63:0]        s5_q0_reg, s5_q1_reg, s5_q2_reg;
    logic [31:0]        m0, m1, m2;

    assign m0 = s4_c0_reg[32] ? 32'(-s4_c0_reg) : s4_c0_reg[31:0];
    assign m1 = s4_c1_reg[32] ? 32'(-s4_c1_reg) : s4_c1_reg[31:0];
    assign m2 = s4_c2_reg[32] ? 32'(-s4_c2_reg) : s4_c2_reg[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s5_q0_reg               <= 64'(m0) * 64'(m0);
        s5_q1_reg               <= 64'(m1) * 64'(m1);
        s5_q2_reg               <= 64'(m2) * 64'(m2);
        s5_d_reg                <= s4_d_reg;
        s5_side_reg.degenerate  <= s4_deg_reg;
        s5_side_reg.cross_y_pos <= !s4_c1_reg[32] && (s4_c1_reg != '0);
    end

    // stage 6: |a x b|^2
    logic               s6_valid_reg;
    vau_side_t          s6_side_reg;
    logic signed [32:0] s6_d_reg;
    logic [63:0]        s6_sq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s6_valid_reg <= 1'b0;
        end
        else
        begin
            s6_valid_reg <= s5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s6_sq_reg   <= s5_q0_reg + s5_q1_reg + s5_q2_reg;
        s6_d_reg    <= s5_d_reg;
        s6_side_reg <= s5_side_reg;
    end

    // stage 7: normalize-shift tests
    logic               s7_valid_reg;
    vau_side_t          s7_side_reg;
    logic signed [32:0] s7_d_reg;
    logic [63:0]        s7_sq_reg;
    logic [29:0]        s7_cond_reg;
    logic [29:0]        cond_next;
    logic [31:0]        ad;

    assign ad = s6_d_reg[32] ? 32'(-s6_d_reg) : s6_d_reg[31:0];

    always_comb
    begin
        for (int s = 0; s < 30; s++)
        begin
            cond_next[s] = ((s6_sq_reg >> (60 - 2 * s)) == 64'd0) &&
                           ((ad >> (31 - s)) == 32'd0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s7_valid_reg <= 1'b0;
        end
        else
        begin
            s7_valid_reg <= s6_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s7_cond_reg <= cond_next;
        s7_sq_reg   <= s6_sq_reg;
        s7_d_reg    <= s6_d_reg;
        s7_side_reg <= s6_side_reg;
    end

    // stage 8: apply shift, feeds square root
    logic                      sq_valid_reg [0:SQRT_STEPS];
    logic [63:0]               sq_n_reg     [0:SQRT_STEPS];
    logic [63:0]               sq_r_reg     [0:SQRT_STEPS];
    logic signed [32:0]        sq_d_reg     [0:SQRT_STEPS];
    vau_side_t                 sq_side_reg  [0:SQRT_STEPS];
    logic [4:0]                shift_sel;

    always_comb
    begin
        shift_sel = 5'd30;
        for (int s = 29; s >= 0; s--)
        begin
            if (!s7_cond_reg[s])
            begin
                shift_sel = 5'(s);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg[0] <= 1'b0;
        end
        else
        begin
            sq_valid_reg[0] <= s7_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_n_reg[0]    <= s7_sq_reg << (2 * shift_sel);
        sq_r_reg[0]    <= '0;
        sq_d_reg[0]    <= 33'(64'(s7_d_reg) <<< shift_sel);
        sq_side_reg[0] <= s7_side_reg;
    end

    for (genvar j = 1; j <= SQRT_STEPS; j++)
    begin : g_sqrt
        localparam logic [63:0] BIT = 64'd1 << (2 * (SQRT_STEPS - j));
        logic [63:0] n_next, r_next;

        always_comb
        begin
            if (sq_n_reg[j-1] >= sq_r_reg[j-1] + BIT)
            begin
                n_next = sq_n_reg[j-1] - (sq_r_reg[j-1] + BIT);
                r_next = (sq_r_reg[j-1] >> 1) + BIT;
            end
            else
            begin
                n_next = sq_n_reg[j-1];
                r_next = sq_r_reg[j-1] >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_valid_reg[j] <= 1'b0;
            end
            else
            begin
                sq_valid_reg[j] <= sq_valid_reg[j-1];
            end
        end

        always_ff @(posedge clk)
        begin
            sq_n_reg[j]    <= n_next;
            sq_r_reg[j]    <= r_next;
            sq_d_reg[j]    <= sq_d_reg[j-1];
            sq_side_reg[j] <= sq_side_reg[j-1];
        end
    end

    // atan2(|a x b|, a.b)
    logic signed [XY_WIDTH-1:0] cx, cy;
    logic                       cz_valid;
    logic signed [Z_WIDTH-1:0]  cz;
    vau_side_t                  cz_side;

    assign cx = XY_WIDTH'(sq_d_reg[SQRT_STEPS]) <<< PRESCALE_BITS;
    assign cy = $signed(XY_WIDTH'({sq_r_reg[SQRT_STEPS][31:0], PRESCALE_BITS'(0)}));

    vau_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_valid_reg[SQRT_STEPS]),
        .in_x      (cx),
        .in_y      (cy),
        .in_side   (sq_side_reg[SQRT_STEPS]),
        .out_valid (cz_valid),
        .out_z     (cz),
        .out_side  (cz_side)
    );

    // clamp, round, sign
    localparam logic signed [Z_WIDTH-1:0] Z_MAX = Z_WIDTH'(180) <<< ACC_FRAC;
    localparam logic [Z_WIDTH-1:0] HALF = Z_WIDTH'(1) << (ACC_FRAC - 1 - ANGLE_FRACTION_BITS);

    logic signed [Z_WIDTH-1:0] zc;
    logic [Z_WIDTH-1:0]        q;
    logic [15:0]               angle_next;

    always_comb
    begin
        if (cz < 0)
        begin
            zc = '0;
        end
        else if (cz > Z_MAX)
        begin
            zc = Z_MAX;
        end
        else
        begin
            zc = cz;
        end
        q = (zc + HALF) >> (ACC_FRAC - ANGLE_FRACTION_BITS);
        if (cz_side.degenerate)
        begin
            angle_next = '0;
        end
        else if (signed_mode_reg && !cz_side.cross_y_pos)
        begin
            angle_next = 16'(-q);
        end
        else
        begin
            angle_next = q[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done <= 1'b0;
        end
        else
        begin
            done <= cz_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        angle_deg  <= angle_next;
        degenerate <= cz_side.degenerate;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("result strobe missing after fixed latency");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && degenerate) |-> (angle_deg == 16'sd0))
        else $error("degenerate result with nonzero angle");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_write && paddr == ADDR_SIGNED_MODE) |=> (signed_mode_reg == $past(pwdata[0])))
        else $error("signed_mode write lost");

endmodule

`default_nettype wire
